### rtl/aet_pkg.sv
// Shared types, character codes and classifier helpers for the expression tokenizer.
package aet_pkg;

  // Widths fixed by the result format
  localparam int unsigned CharW        = 8;
  localparam int unsigned KindW        = 3;
  localparam int unsigned ValueW       = 32;
  localparam int unsigned IdentIndexW  = 4;
  localparam int unsigned IdentLengthW = 5;
  localparam int unsigned DigitW       = 4;

  // Token kinds
  localparam logic [KindW-1:0] KIND_OPERATOR = 3'd0;
  localparam logic [KindW-1:0] KIND_INTEGER  = 3'd1;
  localparam logic [KindW-1:0] KIND_IDENT    = 3'd2;
  localparam logic [KindW-1:0] KIND_UNKNOWN  = 3'd3;
  localparam logic [KindW-1:0] KIND_END      = 3'd4;

  // Character codes
  localparam logic [CharW-1:0] CH_NUL    = 8'h00;
  localparam logic [CharW-1:0] CH_TAB    = 8'h09;
  localparam logic [CharW-1:0] CH_CR     = 8'h0D;
  localparam logic [CharW-1:0] CH_SPACE  = 8'h20;
  localparam logic [CharW-1:0] CH_ZERO   = 8'h30;
  localparam logic [CharW-1:0] CH_NINE   = 8'h39;
  localparam logic [CharW-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CharW-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CharW-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CharW-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CharW-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CharW-1:0] CH_STAR   = 8'h2A;
  localparam logic [CharW-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CharW-1:0] CH_LPAREN = 8'h28;
  localparam logic [CharW-1:0] CH_RPAREN = 8'h29;
  localparam logic [CharW-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CharW-1:0] CH_RBRACK = 8'h5D;

  // Pending-token mode
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_NUM   = 2'd1,
    MODE_IDENT = 2'd2
  } mode_e;

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_EXEC     = 7'b0000010,
    S_MUL      = 7'b0000100,
    S_EMIT_NUM = 7'b0001000,
    S_RD       = 7'b0010000,
    S_EMIT_ID  = 7'b0100000,
    S_TAIL     = 7'b1000000
  } state_e;

  // Accumulator unit operations
  typedef enum logic [1:0] {
    ACC_HOLD     = 2'd0,
    ACC_MUL5     = 2'd1,
    ACC_DBL_ADD  = 2'd2,
    ACC_LOAD     = 2'd3
  } acc_op_e;

  typedef struct packed {
    acc_op_e           op;
    logic [DigitW-1:0] digit;
  } acc_ctrl_t;

  function automatic logic is_digit(input logic [CharW-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_letter(input logic [CharW-1:0] c);
    return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
           ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
  endfunction

  function automatic logic is_space(input logic [CharW-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_operator(input logic [CharW-1:0] c);
    return (c == CH_PLUS) || (c == CH_STAR) || (c == CH_COMMA) ||
           (c == CH_LPAREN) || (c == CH_RPAREN) ||
           (c == CH_LBRACK) || (c == CH_RBRACK);
  endfunction

endpackage

### rtl/aet_accum.sv
// Integer accumulator built around one shared 32-bit adder.
module aet_accum
  import aet_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  acc_ctrl_t         ctrl_i,
  output logic [ValueW-1:0] value_o
);

  logic [ValueW-1:0] acc_q, acc_d;
  logic [ValueW-1:0] opa, opb, sum;

  // acc*10+d as two adder passes: acc*5, then (acc*5)*2+d
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (ctrl_i.op)
      ACC_MUL5: begin
        opa = acc_q << 2;
        opb = acc_q;
      end
      ACC_DBL_ADD: begin
        opa = acc_q << 1;
        opb = {{(ValueW-DigitW){1'b0}}, ctrl_i.digit};
      end
      ACC_LOAD: begin
        opb = {{(ValueW-DigitW){1'b0}}, ctrl_i.digit};
      end
      default: begin
        opa = acc_q;
      end
    endcase
  end

  assign sum   = opa + opb;
  assign acc_d = sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.op != ACC_HOLD) begin
      acc_q <= acc_d;
    end
  end

  assign value_o = acc_q;

endmodule

### rtl/assembler_expression_tokenizer_top.sv
// Top level of the assembler expression tokenizer: sequencer, identifier buffer, result register.
//
// Takes one character per input transaction and emits operator, integer, identifier-character,
// unknown-character and end tokens on the output channel. in_stall_o is low only while the
// sequencer is idle; a finished result can sit in the output register while the next character
// is taken. Per character: one that just extends an identifier (or is dropped past MAX_IDENT)
// is accepted and decoded; a digit that extends an integer is accepted, then makes two passes
// through the shared 32-bit adder in aet_accum to compute acc*10+digit; any other character is
// accepted, decoded, then a final step starts the new token or loads the character's own token.
// When a token ends, the integer is loaded into the result register, or each buffered identifier
// character takes a registered read of the identifier memory, then the result register load.
// Downstream stalls hold the sequencer whenever a result is waiting to be loaded.
// Identifiers keep up to MAX_IDENT characters; longer ones are cut and flagged in ident_truncated_o.
module assembler_expression_tokenizer_top
  import aet_pkg::*;
#(
  parameter int unsigned MAX_IDENT = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // input channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [CharW-1:0]        char_in_i,
  // output channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [KindW-1:0]        token_kind_o,
  output logic [CharW-1:0]        operator_code_o,
  output logic [ValueW-1:0]       integer_value_o,
  output logic [CharW-1:0]        ident_char_o,
  output logic [IdentIndexW-1:0]  ident_index_o,
  output logic [IdentLengthW-1:0] ident_length_o,
  output logic                    ident_truncated_o,
  output logic                    last_o
);

  localparam int unsigned CntW  = $clog2(MAX_IDENT + 1);
  localparam int unsigned AddrW = (MAX_IDENT > 1) ? $clog2(MAX_IDENT) : 1;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_IDENT);

  // Sequencer state
  state_e           state_q, state_d;
  mode_e            mode_q, mode_d;
  logic [CharW-1:0] char_q;
  logic [CntW-1:0]  count_q, count_d;
  logic             ovf_q, ovf_d;
  logic [CntW-1:0]  rd_idx_q, rd_idx_d;

  // Identifier buffer, no reset: only written entries are read
  logic [CharW-1:0] ident_buf_q [MAX_IDENT];
  logic [CharW-1:0] rdata_q;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;

  // Accumulator
  acc_ctrl_t         acc_ctrl;
  logic [ValueW-1:0] acc_value;

  // Result register
  logic                    out_valid_q, out_valid_d;
  logic                    out_load;
  logic [KindW-1:0]        kind_q, kind_d;
  logic [CharW-1:0]        opc_q, opc_d;
  logic [ValueW-1:0]       value_q, value_d;
  logic [CharW-1:0]        ichar_q, ichar_d;
  logic [IdentIndexW-1:0]  iidx_q, iidx_d;
  logic [IdentLengthW-1:0] ilen_q, ilen_d;
  logic                    itrunc_q, itrunc_d;
  logic                    last_q, last_d;

  // Character class of the latched character
  logic c_digit, c_letter, c_space, c_oper, c_nul;
  logic tail_emits;   // the character itself yields a token
  logic out_free;     // result register can take a new result this cycle
  logic id_last_char;

  assign c_digit    = is_digit(char_q);
  assign c_letter   = is_letter(char_q);
  assign c_space    = is_space(char_q);
  assign c_oper     = is_operator(char_q);
  assign c_nul      = (char_q == CH_NUL);
  assign tail_emits = !(c_space || c_digit || c_letter);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign id_last_char = (CntW'(rd_idx_q + CntW'(1)) == count_q);

  aet_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (acc_ctrl),
    .value_o (acc_value)
  );

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    rd_idx_d  = rd_idx_q;
    mem_we    = 1'b0;
    mem_waddr = count_q[AddrW-1:0];
    acc_ctrl.op    = ACC_HOLD;
    acc_ctrl.digit = char_q[DigitW-1:0];
    out_load  = 1'b0;
    kind_d    = KIND_OPERATOR;
    opc_d     = '0;
    value_d   = '0;
    ichar_d   = '0;
    iidx_d    = '0;
    ilen_d    = '0;
    itrunc_d  = 1'b0;
    last_d    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (mode_q == MODE_NUM && c_digit) begin
          acc_ctrl.op = ACC_MUL5;
          state_d     = S_MUL;
        end else if (mode_q == MODE_IDENT && (c_letter || c_digit)) begin
          if (count_q < MaxCnt) begin
            mem_we  = 1'b1;
            count_d = CntW'(count_q + CntW'(1));
          end else begin
            ovf_d = 1'b1;
          end
          state_d = S_IDLE;
        end else if (mode_q == MODE_NUM) begin
          state_d = S_EMIT_NUM;
        end else if (mode_q == MODE_IDENT) begin
          rd_idx_d = '0;
          state_d  = S_RD;
        end else begin
          state_d = S_TAIL;
        end
      end
      S_MUL: begin
        acc_ctrl.op = ACC_DBL_ADD;
        state_d     = S_IDLE;
      end
      S_EMIT_NUM: begin
        if (out_free) begin
          out_load = 1'b1;
          kind_d   = KIND_INTEGER;
          value_d  = acc_value;
          last_d   = !tail_emits;
          state_d  = S_TAIL;
        end
      end
      S_RD: begin
        // buffer read issued this cycle, data lands in rdata_q
        state_d = S_EMIT_ID;
      end
      S_EMIT_ID: begin
        if (out_free) begin
          out_load = 1'b1;
          kind_d   = KIND_IDENT;
          ichar_d  = rdata_q;
          iidx_d   = IdentIndexW'(rd_idx_q);
          ilen_d   = IdentLengthW'(count_q);
          itrunc_d = ovf_q;
          last_d   = id_last_char && !tail_emits;
          if (id_last_char) begin
            state_d = S_TAIL;
          end else begin
            rd_idx_d = CntW'(rd_idx_q + CntW'(1));
            state_d  = S_RD;
          end
        end
      end
      S_TAIL: begin
        if (!tail_emits || out_free) begin
          mode_d  = MODE_IDLE;
          count_d = '0;
          ovf_d   = 1'b0;
          state_d = S_IDLE;
          if (c_digit) begin
            mode_d      = MODE_NUM;
            acc_ctrl.op = ACC_LOAD;
          end else if (c_letter) begin
            mode_d    = MODE_IDENT;
            mem_we    = 1'b1;
            mem_waddr = '0;
            count_d   = CntW'(1);
          end else if (!c_space) begin
            out_load = 1'b1;
            last_d   = 1'b1;
            if (c_nul) begin
              kind_d = KIND_END;
            end else if (c_oper) begin
              kind_d = KIND_OPERATOR;
              opc_d  = char_q;
            end else begin
              kind_d = KIND_UNKNOWN;
              opc_d  = char_q;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input character latch
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      char_q <= char_in_i;
    end
  end

  // Identifier buffer: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ident_buf_q[mem_waddr] <= char_q;
    end
    rdata_q <= ident_buf_q[rd_idx_q[AddrW-1:0]];
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      kind_q   <= kind_d;
      opc_q    <= opc_d;
      value_q  <= value_d;
      ichar_q  <= ichar_d;
      iidx_q   <= iidx_d;
      ilen_q   <= ilen_d;
      itrunc_q <= itrunc_d;
      last_q   <= last_d;
    end
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign token_kind_o      = kind_q;
  assign operator_code_o   = opc_q;
  assign integer_value_o   = value_q;
  assign ident_char_o      = ichar_q;
  assign ident_index_o     = iidx_q;
  assign ident_length_o    = ilen_q;
  assign ident_truncated_o = itrunc_q;
  assign last_o            = last_q;

endmodule
